### design/lc3ic_pkg.sv
// ----------------------------------------------------------------------------
// lc3ic_pkg
// Types and constants shared by the interrupt controller modules.
// ----------------------------------------------------------------------------
package lc3ic_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_PUSH      = 2'd0;
    localparam logic [1:0] OP_PUSH_UNIQ = 2'd1;
    localparam logic [1:0] OP_CHECK     = 2'd2;
    localparam logic [1:0] OP_NONE      = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_QUEUED = 3'd0;
    localparam logic [2:0] ST_DUP    = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_NONE   = 3'd3;
    localparam logic [2:0] ST_TAKEN  = 3'd4;

    localparam logic [7:0]  EXC_LIMIT = 8'h80;
    localparam logic [15:0] VEC_BASE  = 16'h0100;
    localparam logic [15:0] SSP_RESET = 16'h3000;
    localparam logic [15:0] USP_RESET = 16'hF000;

    // Classified request handed from the front end to the execution engine.
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  prio;
        logic [7:0]  vec;
        logic        user;
        logic [2:0]  cpu_prio;
        logic [15:0] psr;
        logic [15:0] pc;
        logic [15:0] r6;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  taken_vector;
        logic [15:0] vector_table_addr;
        logic [15:0] new_r6;
        logic [15:0] psr_word;
        logic [15:0] return_pc;
        logic [2:0]  new_priority;
        logic [15:0] saved_user_sp;
    } t_result;

endpackage

### design/lc3_interrupt_controller_top.sv
// ----------------------------------------------------------------------------
// lc3_interrupt_controller_top
// Priority interrupt controller with an age-ordered pending-request table.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one request or one
//   instruction-boundary check per transaction. Every transaction yields one
//   result transaction on the output channel (o_out_valid / i_out_ready).
//   The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) loads
//   the supervisor stack pointer and is always ready.
//   A two-entry queue decouples input acceptance from the engine, which walks
//   the table one entry per cycle and takes a new command only when idle. A
//   plain queue or an unused op goes straight to the final step; a checked
//   queue or a boundary check first walks all pending entries, and a taken
//   entry then walks the entries behind it to move each of them up by one.
//   Reset empties the table and the queue, sets the saved user stack pointer
//   to 0xF000 and the supervisor stack pointer to 0x3000; no clearing pass.
//   While the receiver stalls, the result is held, the engine waits at its
//   final step and the front queue keeps taking input until it is full.
// ----------------------------------------------------------------------------
module lc3_interrupt_controller_top #(
    parameter int PENDING_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_req_priority,
    input  logic [7:0]  i_req_vector,
    input  logic        i_cpu_user_mode,
    input  logic [2:0]  i_cpu_priority,
    input  logic        i_cc_n,
    input  logic        i_cc_z,
    input  logic        i_cc_p,
    input  logic [15:0] i_cpu_pc,
    input  logic [15:0] i_cpu_r6,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_taken_vector,
    output logic [15:0] o_vector_table_addr,
    output logic [15:0] o_new_r6,
    output logic [15:0] o_psr_word,
    output logic [15:0] o_return_pc,
    output logic [2:0]  o_new_priority,
    output logic [15:0] o_saved_user_sp
);

    logic [15:0]        r_ssp;
    logic               cmd_valid;
    logic               cmd_ready;
    lc3ic_pkg::t_cmd    cmd;
    lc3ic_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssp <= lc3ic_pkg::SSP_RESET;
        end else if (i_cfg_valid) begin
            r_ssp <= i_cfg_data;
        end
    end

    lc3ic_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_req_priority  (i_req_priority),
        .i_req_vector    (i_req_vector),
        .i_cpu_user_mode (i_cpu_user_mode),
        .i_cpu_priority  (i_cpu_priority),
        .i_cc_n          (i_cc_n),
        .i_cc_z          (i_cc_z),
        .i_cc_p          (i_cc_p),
        .i_cpu_pc        (i_cpu_pc),
        .i_cpu_r6        (i_cpu_r6),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_ready     (cmd_ready),
        .o_cmd           (cmd)
    );

    lc3ic_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ssp       (r_ssp),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_status            = result.status;
    assign o_taken_vector      = result.taken_vector;
    assign o_vector_table_addr = result.vector_table_addr;
    assign o_new_r6            = result.new_r6;
    assign o_psr_word          = result.psr_word;
    assign o_return_pc         = result.return_pc;
    assign o_new_priority      = result.new_priority;
    assign o_saved_user_sp     = result.saved_user_sp;

endmodule

### design/lc3ic_front.sv
// ----------------------------------------------------------------------------
// lc3ic_front
// Accepts input transactions, classifies them and buffers them in a
// two-entry queue ahead of the execution engine.
// ----------------------------------------------------------------------------
module lc3ic_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [2:0]         i_req_priority,
    input  logic [7:0]         i_req_vector,
    input  logic               i_cpu_user_mode,
    input  logic [2:0]         i_cpu_priority,
    input  logic               i_cc_n,
    input  logic               i_cc_z,
    input  logic               i_cc_p,
    input  logic [15:0]        i_cpu_pc,
    input  logic [15:0]        i_cpu_r6,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output lc3ic_pkg::t_cmd    o_cmd
);

    lc3ic_pkg::t_cmd r_q [2];
    logic            r_wr_ptr, n_wr_ptr;
    logic            r_rd_ptr, n_rd_ptr;
    logic [1:0]      r_cnt, n_cnt;
    lc3ic_pkg::t_cmd in_cmd;
    logic            push;
    logic            pop;

    // The saved PSR word is formed here so the engine only carries it along.
    always_comb begin
        in_cmd.op       = i_op;
        in_cmd.prio     = i_req_priority;
        in_cmd.vec      = i_req_vector;
        in_cmd.user     = i_cpu_user_mode;
        in_cmd.cpu_prio = i_cpu_priority;
        in_cmd.psr      = {i_cpu_user_mode, 4'b0000, i_cpu_priority, 5'b00000,
                           i_cc_n, i_cc_z, i_cc_p};
        in_cmd.pc       = i_cpu_pc;
        in_cmd.r6       = i_cpu_r6;
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

### design/lc3ic_back.sv
// ----------------------------------------------------------------------------
// lc3ic_back
// Execution engine: owns the pending-request table, scans it one entry per
// cycle, compacts it after a removal and registers the result.
// ----------------------------------------------------------------------------
module lc3ic_back #(
    parameter int PENDING_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_ssp,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  lc3ic_pkg::t_cmd    i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lc3ic_pkg::t_result o_result
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [10:0]        r_mem [PENDING_DEPTH];
    logic [10:0]        r_rd_data;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_issue, n_issue;
    logic               r_pend_vld, n_pend_vld;
    logic [AW-1:0]      r_pend_idx, n_pend_idx;
    logic               r_dup, n_dup;
    logic               r_found, n_found;
    logic [2:0]         r_best_prio, n_best_prio;
    logic [AW-1:0]      r_best_idx, n_best_idx;
    logic [7:0]         r_best_vec, n_best_vec;
    logic [15:0]        r_usp, n_usp;
    logic               r_out_vld, n_out_vld;
    lc3ic_pkg::t_result r_out, n_out;
    lc3ic_pkg::t_cmd    r_cmd, n_cmd;

    logic               mem_rd_en;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [10:0]        mem_wr_data;
    logic               out_free;
    logic               scan_done;
    logic               full;
    logic               qualify;
    logic [2:0]         rd_prio;
    logic [7:0]         rd_vec;
    logic [15:0]        sp_base;

    assign rd_prio   = r_rd_data[10:8];
    assign rd_vec    = r_rd_data[7:0];
    assign out_free  = !r_out_vld || i_out_ready;
    assign scan_done = (r_issue == r_count) && !r_pend_vld;
    assign full      = (r_count == CW'(PENDING_DEPTH));
    assign qualify   = (r_cmd.cpu_prio < rd_prio) ||
                       ((r_cmd.cpu_prio == rd_prio) && (rd_vec < lc3ic_pkg::EXC_LIMIT));
    assign sp_base   = r_cmd.user ? i_ssp : r_cmd.r6;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_pend_vld  = r_pend_vld;
        n_pend_idx  = r_pend_idx;
        n_dup       = r_dup;
        n_found     = r_found;
        n_best_prio = r_best_prio;
        n_best_idx  = r_best_idx;
        n_best_vec  = r_best_vec;
        n_usp       = r_usp;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        n_cmd       = r_cmd;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_count[AW-1:0];
        mem_wr_data = {r_cmd.prio, r_cmd.vec};

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd      = i_cmd;
                    n_issue    = '0;
                    n_pend_vld = 1'b0;
                    n_dup      = 1'b0;
                    n_found    = 1'b0;
                    if (i_cmd.op == lc3ic_pkg::OP_PUSH_UNIQ ||
                        i_cmd.op == lc3ic_pkg::OP_CHECK) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN, S_SHIFT: begin
                // Reads are issued one entry ahead of the compare or move stage.
                if (r_issue < r_count) begin
                    mem_rd_en  = 1'b1;
                    n_issue    = r_issue + CW'(1);
                    n_pend_vld = 1'b1;
                    n_pend_idx = r_issue[AW-1:0];
                end else begin
                    n_pend_vld = 1'b0;
                end
                if (r_pend_vld) begin
                    if (r_state == S_SCAN) begin
                        if (rd_prio == r_cmd.prio && rd_vec == r_cmd.vec) begin
                            n_dup = 1'b1;
                        end
                        if (qualify && (!r_found || rd_prio > r_best_prio)) begin
                            n_found     = 1'b1;
                            n_best_prio = rd_prio;
                            n_best_idx  = r_pend_idx;
                            n_best_vec  = rd_vec;
                        end
                    end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_pend_idx - AW'(1);
                        mem_wr_data = r_rd_data;
                    end
                end
                if (scan_done) begin
                    if (r_state == S_SCAN && r_cmd.op == lc3ic_pkg::OP_CHECK && r_found) begin
                        n_issue = CW'(r_best_idx) + CW'(1);
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out     = '0;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    case (r_cmd.op) inside
                        lc3ic_pkg::OP_PUSH, lc3ic_pkg::OP_PUSH_UNIQ: begin
                            if (r_cmd.op == lc3ic_pkg::OP_PUSH_UNIQ && r_dup) begin
                                n_out.status = lc3ic_pkg::ST_DUP;
                            end else if (full) begin
                                n_out.status = lc3ic_pkg::ST_FULL;
                            end else begin
                                mem_wr_en    = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_out.status = lc3ic_pkg::ST_QUEUED;
                            end
                        end
                        lc3ic_pkg::OP_CHECK: begin
                            if (r_found) begin
                                n_count                 = r_count - CW'(1);
                                if (r_cmd.user) begin
                                    n_usp = r_cmd.r6;
                                end
                                n_out.status            = lc3ic_pkg::ST_TAKEN;
                                n_out.taken_vector      = r_best_vec;
                                n_out.vector_table_addr = lc3ic_pkg::VEC_BASE |
                                                          {8'h00, r_best_vec};
                                n_out.new_r6            = sp_base - 16'd2;
                                n_out.psr_word          = r_cmd.psr;
                                n_out.return_pc         = r_cmd.pc;
                                n_out.new_priority      = r_best_prio;
                            end else begin
                                n_out.status = lc3ic_pkg::ST_NONE;
                            end
                        end
                        default: begin
                            n_out.status = lc3ic_pkg::ST_NONE;
                        end
                    endcase
                    n_out.saved_user_sp = n_usp;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pend_vld <= 1'b0;
            r_usp      <= lc3ic_pkg::USP_RESET;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
            r_usp      <= n_usp;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue     <= n_issue;
        r_pend_idx  <= n_pend_idx;
        r_dup       <= n_dup;
        r_found     <= n_found;
        r_best_prio <= n_best_prio;
        r_best_idx  <= n_best_idx;
        r_best_vec  <= n_best_vec;
        r_out       <= n_out;
        r_cmd       <= n_cmd;
    end

    // Pending table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[r_issue[AW-1:0]];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(PENDING_DEPTH))
        else $error("pending count exceeds table depth");

    a_take_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free && r_cmd.op == lc3ic_pkg::OP_CHECK && r_found)
        |=> r_count == $past(r_count) - CW'(1))
        else $error("taken interrupt did not remove a table entry");

    a_shift_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend_vld) |-> r_pend_idx != '0)
        else $error("compaction moved the head entry");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_vld)
        else $error("read pipeline busy while engine is idle");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LC-3 priority interrupt controller.
// Requests and boundary checks go in through the input channel under random
// gaps. Every input transaction is run through a software copy of the
// pending table and the stack logic. Every output transaction is matched
// field by field against the oldest predicted outcome. The supervisor stack
// pointer is reloaded between phases, and each reload waits for the block to
// drain.
// ----------------------------------------------------------------------------
module tb;

    localparam int PENDING_DEPTH = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 32;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  prio;
        logic [7:0]  vec;
        logic        user;
        logic [2:0]  cpu_prio;
        logic        cc_n;
        logic        cc_z;
        logic        cc_p;
        logic [15:0] pc;
        logic [15:0] r6;
    } t_ic_req;

    class t_ic_scoreboard;
        logic [2:0]         pend_prio[$];
        logic [7:0]         pend_vec[$];
        logic [15:0]        ssp;
        logic [15:0]        usp;
        lc3ic_pkg::t_result outcome_q[$];
        int                 errors;
        int                 n_requests;
        int                 n_user_entries;
        int                 n_status[5];

        function new();
            ssp = lc3ic_pkg::SSP_RESET;
            usp = lc3ic_pkg::USP_RESET;
            errors = 0;
            n_requests = 0;
            n_user_entries = 0;
            foreach (n_status[i]) n_status[i] = 0;
        endfunction

        function logic [2:0] push_entry(logic [2:0] prio, logic [7:0] vec);
            if (pend_prio.size() >= PENDING_DEPTH) return lc3ic_pkg::ST_FULL;
            pend_prio.insert(pend_prio.size(), prio);
            pend_vec.insert(pend_vec.size(), vec);
            return lc3ic_pkg::ST_QUEUED;
        endfunction

        function lc3ic_pkg::t_result predict_outcome(t_ic_req r);
            lc3ic_pkg::t_result res;
            logic               found;
            logic               dup;
            int                 best;
            logic [2:0]         best_prio;
            logic [15:0]        sp;
            res = '0;
            case (r.op)
                lc3ic_pkg::OP_PUSH: res.status = push_entry(r.prio, r.vec);
                lc3ic_pkg::OP_PUSH_UNIQ: begin
                    dup = 1'b0;
                    foreach (pend_prio[k])
                        if (pend_prio[k] == r.prio && pend_vec[k] == r.vec) dup = 1'b1;
                    // The duplicate test wins over the full test.
                    res.status = dup ? lc3ic_pkg::ST_DUP : push_entry(r.prio, r.vec);
                end
                lc3ic_pkg::OP_CHECK: begin
                    found = 1'b0;
                    best = 0;
                    best_prio = '0;
                    foreach (pend_prio[k]) begin
                        if (r.cpu_prio < pend_prio[k] ||
                            (r.cpu_prio == pend_prio[k] &&
                             pend_vec[k] < lc3ic_pkg::EXC_LIMIT)) begin
                            // Strictly greater keeps the oldest among equals.
                            if (!found || pend_prio[k] > best_prio) begin
                                found = 1'b1;
                                best_prio = pend_prio[k];
                                best = k;
                            end
                        end
                    end
                    if (!found) begin
                        res.status = lc3ic_pkg::ST_NONE;
                    end else begin
                        res.status = lc3ic_pkg::ST_TAKEN;
                        res.taken_vector = pend_vec[best];
                        res.vector_table_addr = lc3ic_pkg::VEC_BASE | {8'h00, pend_vec[best]};
                        pend_prio.delete(best);
                        pend_vec.delete(best);
                        if (r.user) begin
                            usp = r.r6;
                            sp = ssp;
                            n_user_entries++;
                        end else begin
                            sp = r.r6;
                        end
                        res.new_r6 = sp - 16'd2;
                        res.psr_word = {r.user, 4'b0, r.cpu_prio, 5'b0, r.cc_n, r.cc_z, r.cc_p};
                        res.return_pc = r.pc;
                        res.new_priority = best_prio;
                    end
                end
                default: res.status = lc3ic_pkg::ST_NONE;
            endcase
            res.saved_user_sp = usp;
            return res;
        endfunction

        function void note_request(t_ic_req r);
            outcome_q.insert(outcome_q.size(), predict_outcome(r));
            n_requests++;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(lc3ic_pkg::t_result got);
            lc3ic_pkg::t_result want;
            if (outcome_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            want = outcome_q[0];
            outcome_q.delete(0);
            if (got.status < 5) n_status[got.status]++;
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("taken_vector", 16'(want.taken_vector), 16'(got.taken_vector));
            compare_field("vector_table_addr", want.vector_table_addr, got.vector_table_addr);
            compare_field("new_r6", want.new_r6, got.new_r6);
            compare_field("psr_word", want.psr_word, got.psr_word);
            compare_field("return_pc", want.return_pc, got.return_pc);
            compare_field("new_priority", 16'(want.new_priority), 16'(got.new_priority));
            compare_field("saved_user_sp", want.saved_user_sp, got.saved_user_sp);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [2:0]  i_req_priority;
    logic [7:0]  i_req_vector;
    logic        i_cpu_user_mode;
    logic [2:0]  i_cpu_priority;
    logic        i_cc_n;
    logic        i_cc_z;
    logic        i_cc_p;
    logic [15:0] i_cpu_pc;
    logic [15:0] i_cpu_r6;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [7:0]  o_taken_vector;
    logic [15:0] o_vector_table_addr;
    logic [15:0] o_new_r6;
    logic [15:0] o_psr_word;
    logic [15:0] o_return_pc;
    logic [2:0]  o_new_priority;
    logic [15:0] o_saved_user_sp;

    t_ic_scoreboard sb;
    int             tx_idle_pct;
    int             rx_idle_pct;
    int             n_settings;

    lc3_interrupt_controller_top #(
        .PENDING_DEPTH(PENDING_DEPTH)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_req_priority     (i_req_priority),
        .i_req_vector       (i_req_vector),
        .i_cpu_user_mode    (i_cpu_user_mode),
        .i_cpu_priority     (i_cpu_priority),
        .i_cc_n             (i_cc_n),
        .i_cc_z             (i_cc_z),
        .i_cc_p             (i_cc_p),
        .i_cpu_pc           (i_cpu_pc),
        .i_cpu_r6           (i_cpu_r6),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_taken_vector     (o_taken_vector),
        .o_vector_table_addr(o_vector_table_addr),
        .o_new_r6           (o_new_r6),
        .o_psr_word         (o_psr_word),
        .o_return_pc        (o_return_pc),
        .o_new_priority     (o_new_priority),
        .o_saved_user_sp    (o_saved_user_sp)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitors sample at the edge, so they see the values that the edge accepts.
    always @(posedge i_clk) begin : in_monitor
        t_ic_req seen;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            seen.op = i_op;
            seen.prio = i_req_priority;
            seen.vec = i_req_vector;
            seen.user = i_cpu_user_mode;
            seen.cpu_prio = i_cpu_priority;
            seen.cc_n = i_cc_n;
            seen.cc_z = i_cc_z;
            seen.cc_p = i_cc_p;
            seen.pc = i_cpu_pc;
            seen.r6 = i_cpu_r6;
            sb.note_request(seen);
        end
    end

    always @(posedge i_clk) begin : out_monitor
        lc3ic_pkg::t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status = o_status;
            got.taken_vector = o_taken_vector;
            got.vector_table_addr = o_vector_table_addr;
            got.new_r6 = o_new_r6;
            got.psr_word = o_psr_word;
            got.return_pc = o_return_pc;
            got.new_priority = o_new_priority;
            got.saved_user_sp = o_saved_user_sp;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) sb.ssp = i_cfg_data;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic t_ic_req make_req(logic [1:0] op, logic [2:0] prio, logic [7:0] vec,
                                         logic user, logic [2:0] cpu_prio);
        t_ic_req r;
        r.op = op;
        r.prio = prio;
        r.vec = vec;
        r.user = user;
        r.cpu_prio = cpu_prio;
        r.cc_n = 1'($urandom_range(1));
        r.cc_z = 1'($urandom_range(1));
        r.cc_p = 1'($urandom_range(1));
        r.pc = 16'($urandom_range(16'hFFFF));
        r.r6 = 16'($urandom_range(16'hFFFF));
        return r;
    endfunction

    // Mostly queue traffic and boundary checks; a small vector pool makes
    // duplicate hits and equal-priority ties common.
    function automatic t_ic_req random_request();
        t_ic_req r;
        int      pick;
        r = make_req(lc3ic_pkg::OP_PUSH, 3'($urandom_range(7)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), 3'($urandom_range(7)));
        pick = $urandom_range(99);
        if (pick < 35)      r.op = lc3ic_pkg::OP_PUSH;
        else if (pick < 60) r.op = lc3ic_pkg::OP_PUSH_UNIQ;
        else if (pick < 96) r.op = lc3ic_pkg::OP_CHECK;
        else                r.op = lc3ic_pkg::OP_NONE;
        if ($urandom_range(1)) begin
            r.prio = 3'($urandom_range(3) * 2 + 1);
            case ($urandom_range(3))
                0: r.vec = 8'h00;
                1: r.vec = 8'h7F;
                2: r.vec = 8'h80;
                default: r.vec = 8'hFF;
            endcase
        end
        if ($urandom_range(1)) r.cpu_prio = 3'($urandom_range(3));
        return r;
    endfunction

    // Drives the item after a random idle gap, then waits until o_in_ready reads high after an edge.
    task automatic send_request(t_ic_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= r.op;
        i_req_priority <= r.prio;
        i_req_vector <= r.vec;
        i_cpu_user_mode <= r.user;
        i_cpu_priority <= r.cpu_prio;
        i_cc_n <= r.cc_n;
        i_cc_z <= r.cc_z;
        i_cc_p <= r.cc_p;
        i_cpu_pc <= r.pc;
        i_cpu_r6 <= r.r6;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_ssp(logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_directed();
        t_ic_req r;
        send_request(make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b1, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH, 3'd7, 8'hFF, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH_UNIQ, 3'd7, 8'hFF, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH, 3'd0, 8'h00, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH, 3'd3, 8'h7F, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH, 3'd3, 8'h80, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH_UNIQ, 3'd5, 8'h10, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH, 3'd5, 8'h20, 1'b0, 3'd0));
        // A plain request is queued even when an identical one is pending.
        send_request(make_req(lc3ic_pkg::OP_PUSH, 3'd5, 8'h10, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH_UNIQ, 3'd1, 8'h01, 1'b0, 3'd0));
        // The table is full now.
        send_request(make_req(lc3ic_pkg::OP_PUSH, 3'd2, 8'h02, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH_UNIQ, 3'd0, 8'h00, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_PUSH_UNIQ, 3'd6, 8'h66, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_NONE, 3'd7, 8'hFF, 1'b1, 3'd7));
        // Equal priority with a vector at or above the exception limit does not qualify.
        send_request(make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b0, 3'd7));
        r = make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b1, 3'd6);
        r.pc = 16'hFFFF;
        r.r6 = 16'h0000;
        {r.cc_n, r.cc_z, r.cc_p} = 3'b111;
        send_request(r);
        r = make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b0, 3'd5);
        r.pc = 16'h0000;
        r.r6 = 16'h0001;
        {r.cc_n, r.cc_z, r.cc_p} = 3'b000;
        send_request(r);
        r = make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b1, 3'd3);
        r.r6 = 16'hFFFF;
        send_request(r);
        send_request(make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b0, 3'd3));
        send_request(make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b0, 3'd3));
        send_request(make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b1, 3'd3));
        send_request(make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b1, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b0, 3'd0));
        send_request(make_req(lc3ic_pkg::OP_CHECK, 3'd0, 8'h00, 1'b0, 3'd0));
    endtask

    task automatic run_random(int count);
        t_ic_req r;
        int      done;
        done = 0;
        while (done < count) begin
            r = random_request();
            send_request(r);
            if (r.op != lc3ic_pkg::OP_NONE) done++;
        end
    endtask

    initial begin
        logic [15:0] ssp_plan[6];
        sb = new();
        n_settings = 1;
        tx_idle_pct = 10;
        rx_idle_pct = 54;
        ssp_plan[0] = 16'h0000;
        ssp_plan[1] = 16'hFFFF;
        ssp_plan[2] = 16'h0001;
        ssp_plan[3] = 16'($urandom_range(16'hFFFF));
        ssp_plan[4] = 16'h8000;
        ssp_plan[5] = 16'($urandom_range(16'hFFFF));
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_op <= lc3ic_pkg::OP_NONE;
        i_req_priority <= '0;
        i_req_vector <= '0;
        i_cpu_user_mode <= 1'b0;
        i_cpu_priority <= '0;
        i_cc_n <= 1'b0;
        i_cc_z <= 1'b0;
        i_cc_p <= 1'b0;
        i_cpu_pc <= '0;
        i_cpu_r6 <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed part runs with the reset value of the stack pointer.
        run_directed();
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                tx_idle_pct = 54;
                rx_idle_pct = 10;
            end else if (ph == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_ssp(ssp_plan[ph]);
            run_random(265);
            drain();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d transactions under %0d supervisor stack settings.",
                 sb.n_requests, n_settings);
        $display("Outcomes: %0d queued, %0d dup, %0d full, %0d none, %0d taken (%0d user).",
                 sb.n_status[lc3ic_pkg::ST_QUEUED], sb.n_status[lc3ic_pkg::ST_DUP],
                 sb.n_status[lc3ic_pkg::ST_FULL], sb.n_status[lc3ic_pkg::ST_NONE],
                 sb.n_status[lc3ic_pkg::ST_TAKEN], sb.n_user_entries);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
